[src/swt_pkg.sv]
// Shared types, result codes and character constants of the shell word tokenizer.
package swt_pkg;

    localparam int unsigned MAX_RESULTS = 3;

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_EOW  = 2'd1;
    localparam logic [1:0] KIND_EOC  = 2'd2;

    localparam logic [15:0] MAX_WORD_BYTES_RESET = 16'd255;

    // Characters the lexer reacts to
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_X  = 8'h78;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       ovf;
    } result_t;

    // All results raised by one input byte, item 0 first
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] item;
        logic [1:0]                count;
    } bundle_t;

endpackage

[src/swt_lexer.sv]
// Lexer state and per-byte decode: produces the result bundle for each accepted byte.
module swt_lexer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_wdata,
    output swt_pkg::bundle_t bundle
);
    import swt_pkg::*;

    typedef enum logic [3:0] {
        M_NORMAL   = 4'd0,
        M_COMMENT  = 4'd1,
        M_ESC      = 4'd2,
        M_HEXSTART = 4'd3,
        M_DIGITS   = 4'd4,
        M_SQ       = 4'd5,
        M_SQ_ESC   = 4'd6,
        M_DQ       = 4'd7,
        M_DQ_ESC   = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_BLANK,
        OP_NEWLINE
    } op_t;

    mode_t       mode_reg, mode_next;
    logic [7:0]  esc_val_reg, esc_val_next;
    logic        esc_hex_reg, esc_hex_next;
    logic [1:0]  digits_left_reg, digits_left_next;
    logic [15:0] word_cnt_reg, word_cnt_next;
    logic        ovf_reg, ovf_next;
    logic        cmd_words_reg, cmd_words_next;
    logic [15:0] max_bytes_reg;

    logic        pre_add;
    op_t         op;
    logic [7:0]  op_byte;
    logic [4:0]  dig;

    // Hex digit value in either case; bit 4 set when not a digit
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd16;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b0, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            r = 5'(c[3:0]) + 5'd9;
        return r;
    endfunction

    assign dig = digit_of(in_byte);

    // Mode decode: an optional escape byte first, then one action on the byte
    always_comb
    begin
        logic       normal;
        logic [7:0] shifted;
        logic [7:0] acc;
        normal           = 1'b0;
        shifted          = '0;
        acc              = '0;
        mode_next        = mode_reg;
        esc_val_next     = esc_val_reg;
        esc_hex_next     = esc_hex_reg;
        digits_left_next = digits_left_reg;
        pre_add          = 1'b0;
        op               = OP_NONE;
        op_byte          = in_byte;
        unique case (mode_reg)
            M_COMMENT:
            begin
                if (in_byte == CH_LF)
                begin
                    mode_next = M_NORMAL;
                    op        = OP_NEWLINE;
                end
            end
            M_ESC:
            begin
                mode_next = M_NORMAL;
                priority if (in_byte == CH_LOW_T)
                begin
                    op = OP_ADD; op_byte = CH_TAB;
                end
                else if (in_byte == CH_LOW_B)
                begin
                    op = OP_ADD; op_byte = CH_BS;
                end
                else if (in_byte == CH_LOW_R)
                begin
                    op = OP_ADD; op_byte = CH_CR;
                end
                else if (in_byte == CH_LOW_N)
                begin
                    op = OP_ADD; op_byte = CH_LF;
                end
                else if (in_byte == CH_LF)
                    op = OP_BLANK;
                else if (in_byte == CH_LOW_X)
                    mode_next = M_HEXSTART;
                else if (!dig[4] && !dig[3])
                begin
                    esc_val_next     = {4'd0, dig[3:0]};
                    esc_hex_next     = 1'b0;
                    digits_left_next = 2'd2;
                    mode_next        = M_DIGITS;
                end
                else
                    op = OP_ADD;
            end
            M_HEXSTART:
            begin
                if (!dig[4])
                begin
                    esc_val_next     = {4'd0, dig[3:0]};
                    esc_hex_next     = 1'b1;
                    digits_left_next = 2'd1;
                    mode_next        = M_DIGITS;
                end
                else
                begin
                    mode_next = M_NORMAL;
                    op        = OP_ADD;
                end
            end
            M_DIGITS:
            begin
                shifted = esc_hex_reg ? {esc_val_reg[3:0], 4'd0} : {esc_val_reg[4:0], 3'd0};
                acc     = shifted + {4'd0, dig[3:0]};
                if (!dig[4] && (esc_hex_reg || !dig[3]) && digits_left_reg != 2'd0)
                begin
                    esc_val_next     = acc;
                    digits_left_next = digits_left_reg - 2'd1;
                    if (digits_left_reg == 2'd1)
                    begin
                        mode_next = M_NORMAL;
                        op        = OP_ADD;
                        op_byte   = acc;
                    end
                end
                else
                begin
                    // escape ends: its value goes out, then the byte is lexed as usual
                    digits_left_next = 2'd0;
                    pre_add          = 1'b1;
                    normal           = 1'b1;
                end
            end
            M_SQ:
            begin
                if (in_byte == CH_SQUOTE)
                    mode_next = M_NORMAL;
                else if (in_byte == CH_BSLASH)
                    mode_next = M_SQ_ESC;
                else
                    op = OP_ADD;
            end
            M_SQ_ESC:
            begin
                mode_next = M_SQ;
                if (in_byte != CH_LF)
                    op = OP_ADD;
            end
            M_DQ:
            begin
                if (in_byte == CH_DQUOTE)
                    mode_next = M_NORMAL;
                else if (in_byte == CH_BSLASH)
                    mode_next = M_DQ_ESC;
                else
                    op = OP_ADD;
            end
            M_DQ_ESC:
            begin
                mode_next = M_DQ;
                if (in_byte != CH_LF)
                    op = OP_ADD;
            end
            default:
                normal = 1'b1;
        endcase

        if (normal)
        begin
            mode_next = M_NORMAL;
            priority if (in_byte == CH_HASH)
                mode_next = M_COMMENT;
            else if (in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_CR)
                op = OP_BLANK;
            else if (in_byte == CH_LF)
                op = OP_NEWLINE;
            else if (in_byte == CH_SQUOTE)
                mode_next = M_SQ;
            else if (in_byte == CH_DQUOTE)
                mode_next = M_DQ;
            else if (in_byte == CH_BSLASH)
                mode_next = M_ESC;
            else
            begin
                op      = OP_ADD;
                op_byte = in_byte;
            end
        end
    end

    // Word bookkeeping and result list
    always_comb
    begin
        logic [15:0] wc;
        logic        ov;
        logic        cw;
        logic [1:0]  n;
        wc     = word_cnt_reg;
        ov     = ovf_reg;
        cw     = cmd_words_reg;
        n      = 2'd0;
        bundle = '0;
        if (pre_add)
        begin
            if (wc < max_bytes_reg)
            begin
                bundle.item[0] = '{kind: KIND_BYTE, data: esc_val_reg, ovf: 1'b0};
                n  = 2'd1;
                wc = wc + 16'd1;
            end
            else
                ov = 1'b1;
        end
        unique case (op)
            OP_ADD:
            begin
                if (wc < max_bytes_reg)
                begin
                    bundle.item[n] = '{kind: KIND_BYTE, data: op_byte, ovf: 1'b0};
                    n  = n + 2'd1;
                    wc = wc + 16'd1;
                end
                else
                    ov = 1'b1;
            end
            OP_BLANK, OP_NEWLINE:
            begin
                if (wc != 16'd0 || ov)
                begin
                    bundle.item[n] = '{kind: KIND_EOW, data: 8'd0, ovf: ov};
                    n  = n + 2'd1;
                    cw = 1'b1;
                    wc = 16'd0;
                    ov = 1'b0;
                end
                if (op == OP_NEWLINE && cw)
                begin
                    bundle.item[n] = '{kind: KIND_EOC, data: 8'd0, ovf: 1'b0};
                    n  = n + 2'd1;
                    cw = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        bundle.count   = n;
        word_cnt_next  = wc;
        ovf_next       = ov;
        cmd_words_next = cw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= M_NORMAL;
            esc_val_reg     <= '0;
            esc_hex_reg     <= 1'b0;
            digits_left_reg <= '0;
            word_cnt_reg    <= '0;
            ovf_reg         <= 1'b0;
            cmd_words_reg   <= 1'b0;
            max_bytes_reg   <= MAX_WORD_BYTES_RESET;
        end
        else
        begin
            if (cfg_we)
                max_bytes_reg <= cfg_wdata;
            if (accept)
            begin
                mode_reg        <= mode_next;
                esc_val_reg     <= esc_val_next;
                esc_hex_reg     <= esc_hex_next;
                digits_left_reg <= digits_left_next;
                word_cnt_reg    <= word_cnt_next;
                ovf_reg         <= ovf_next;
                cmd_words_reg   <= cmd_words_next;
            end
        end
    end

endmodule

[src/swt_out_seq.sv]
// Result register and serialiser: holds one byte's results and sends them one per transfer.
module swt_out_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  swt_pkg::bundle_t bundle,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       out_kind,
    output logic [7:0]       out_data,
    output logic             out_ovf,
    output logic             out_last
);
    import swt_pkg::*;

    bundle_t    bundle_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       pop;
    result_t    cur;

    assign cur       = bundle_reg.item[idx_reg];
    assign out_last  = (idx_reg == bundle_reg.count - 2'd1);
    assign out_valid = valid_reg;
    assign out_kind  = cur.kind;
    assign out_data  = cur.data;
    assign out_ovf   = cur.ovf;
    assign pop       = valid_reg && out_ready;
    // Next byte may enter as the final result of the current one leaves
    assign in_ready  = !valid_reg || (out_ready && out_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            // a new bundle replaces the one whose final result is leaving
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= '0;
            end
            else if (pop)
            begin
                if (out_last)
                    valid_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            bundle_reg <= bundle;
    end

endmodule

[src/shell_word_tokenizer_core.sv]
// Top level of the shell word tokenizer: lexer stage feeding the result serialiser.
//
//  channel          | direction | transfer carries
//  s_axis           | in        | one command byte
//  m_axis           | out       | word byte, end of word or end of command
//  max_word_bytes   | in        | word length limit, written when max_word_bytes_we is high
//
//  A byte is lexed in the cycle it is accepted; its results (0 to 3) appear from the next
//  cycle, one per m_axis transfer. Sustained rate is one byte per cycle while m_axis is
//  ready and each byte yields at most one result; more results hold the input until the
//  last leaves. Bytes yielding no result pass without touching the output. Reset (rst_n,
//  asynchronous) returns the lexer to between words and the limit to 255.
module shell_word_tokenizer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] word_overflow
    output logic        m_axis_tlast,
    input  logic        max_word_bytes_we,
    input  logic [15:0] max_word_bytes
);
    import swt_pkg::*;

    logic    in_xfer;
    bundle_t bundle;
    logic    load;
    logic [1:0] kind;
    logic       ovf;

    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign load    = in_xfer && (bundle.count != 2'd0);

    swt_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_xfer),
        .in_byte   (s_axis_tdata),
        .cfg_we    (max_word_bytes_we),
        .cfg_wdata (max_word_bytes),
        .bundle    (bundle)
    );

    swt_out_seq u_out_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .bundle    (bundle),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (kind),
        .out_data  (m_axis_tdata),
        .out_ovf   (ovf),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = {ovf, kind};

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> m_axis_tvalid)
        else $error("results of an accepted byte not presented");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("result run cut short");

    a_ovf_on_eow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] != KIND_EOW) |-> !m_axis_tuser[2])
        else $error("overflow flag outside end of word");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] != KIND_BYTE) |-> (m_axis_tdata == 8'd0))
        else $error("nonzero byte on a marker result");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule
